>>> rtl/assert_macros.svh
// Assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define CHK_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("check failed");

// Check a property on every rising clock edge, reset included
`define CHK_RESET(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("reset check failed");

`endif

>>> rtl/fbrgb_pkg.sv
// Shared types, constants and tables for the bin-to-color pipeline
`timescale 1ns / 1ps
`default_nettype none
package fbrgb_pkg;

    localparam int ANGLE_STEPS = 16;
    localparam int DIV_STEPS   = 16;
    localparam int NUM_CELLS   = (ANGLE_STEPS > DIV_STEPS) ? ANGLE_STEPS : DIV_STEPS;
    localparam int IDX_W       = $clog2(NUM_CELLS);
    localparam int XY_W        = 27;
    localparam int Z_W         = 26;

    localparam logic [16:0] ONE_Q16    = 17'h10000;
    localparam logic [15:0] LEVEL_HALF = 16'd8192;
    localparam logic [22:0] DEG60_Q16  = 23'd3932160;
    localparam logic [22:0] HUE_MAX    = 23'd5898239;
    localparam logic [22:0] RECIP60    = 23'd4473925;
    localparam int          RECIP_SH   = 28;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [23:0]            rem;
        logic [23:0]            mag;
        logic [15:0]            quot;
        logic [16:0]            v;
        logic                   re_pos;
        logic                   sat_full;
        logic                   active;
        logic                   last;
    } cell_data_t;

    // atan(2^-i) in degrees, Q.16
    function automatic logic [21:0] atan_q16(input logic [4:0] i);
        logic [21:0] r;
        case (i)
            5'd0:  r = 22'd2949120;
            5'd1:  r = 22'd1740967;
            5'd2:  r = 22'd919879;
            5'd3:  r = 22'd466945;
            5'd4:  r = 22'd234379;
            5'd5:  r = 22'd117304;
            5'd6:  r = 22'd58666;
            5'd7:  r = 22'd29335;
            5'd8:  r = 22'd14668;
            5'd9:  r = 22'd7334;
            5'd10: r = 22'd3667;
            5'd11: r = 22'd1833;
            5'd12: r = 22'd917;
            5'd13: r = 22'd458;
            5'd14: r = 22'd229;
            5'd15: r = 22'd115;
            5'd16: r = 22'd57;
            5'd17: r = 22'd29;
            5'd18: r = 22'd14;
            5'd19: r = 22'd7;
            5'd20: r = 22'd4;
            5'd21: r = 22'd2;
            5'd22: r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/fft_bin_to_rgb_color_core.sv
// The pipeline has 3 front stages, NUM_CELLS chain cells and 5 back stages.
// Throughput: one bin per cycle while the output is not stalled; each chain cell does one CORDIC and one divide step.
// A stalled output beat freezes the whole pipeline and stalls the input for that cycle.
// Reset clears all valid bits and sets weight_reg to 256 (1.0).
// Top level: spectrum bin to RGB pixel converter
`timescale 1ns / 1ps
`default_nettype none
module fft_bin_to_rgb_color_core
    import fbrgb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [15:0]        cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [23:0] real_part,
    input  wire logic [23:0]        magnitude,
    input  wire logic [15:0]        level,
    input  wire logic               last_bin,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              red,
    output logic [7:0]              green,
    output logic [7:0]              blue,
    output logic                    last_pixel
);

    logic [15:0] weight_reg;
    logic        en;
    logic        chain_vld [NUM_CELLS+1];
    cell_data_t  chain_dat [NUM_CELLS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= 16'd256;
        end
        else if (cfg_wr_en)
        begin
            weight_reg <= cfg_wr_data;
        end
    end

    // hold everything while the output beat is stalled
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    fbrgb_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (in_valid),
        .real_part (real_part),
        .magnitude (magnitude),
        .level     (level),
        .last_bin  (last_bin),
        .weight    (weight_reg),
        .out_vld   (chain_vld[0]),
        .out_data  (chain_dat[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        fbrgb_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .idx      (IDX_W'(g)),
            .in_vld   (chain_vld[g]),
            .in_data  (chain_dat[g]),
            .out_vld  (chain_vld[g+1]),
            .out_data (chain_dat[g+1])
        );
    end

    fbrgb_tail u_tail (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (chain_vld[NUM_CELLS]),
        .in_data (chain_dat[NUM_CELLS]),
        .out_vld (out_valid),
        .red     (red),
        .green   (green),
        .blue    (blue),
        .last    (last_pixel)
    );

endmodule
`default_nettype wire

>>> rtl/fbrgb_prep.sv
// Front stages: level cube, value gain and cell chain seeding
`timescale 1ns / 1ps
`default_nettype none
module fbrgb_prep
    import fbrgb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_vld,
    input  wire logic signed [23:0] real_part,
    input  wire logic [23:0]        magnitude,
    input  wire logic [15:0]        level,
    input  wire logic               last_bin,
    input  wire logic [15:0]        weight,
    output logic                    out_vld,
    output cell_data_t              out_data
);

    logic               vld1_reg, vld2_reg, vld3_reg;
    logic signed [23:0] re1_reg, re2_reg;
    logic [23:0]        mag1_reg, mag2_reg;
    logic [15:0]        lvl1_reg, lvl2_reg;
    logic               last1_reg, last2_reg;
    logic [31:0]        sq1_reg;
    logic [47:0]        cube2_reg;
    cell_data_t         d3_reg, d3_next;
    logic [63:0]        prod;
    logic [29:0]        vq;
    logic               re_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re1_reg   <= real_part;
            mag1_reg  <= magnitude;
            lvl1_reg  <= level;
            last1_reg <= last_bin;
            sq1_reg   <= level * level;
            re2_reg   <= re1_reg;
            mag2_reg  <= mag1_reg;
            lvl2_reg  <= lvl1_reg;
            last2_reg <= last1_reg;
            cube2_reg <= sq1_reg * lvl1_reg;
            d3_reg    <= d3_next;
        end
    end

    always_comb
    begin
        prod   = cube2_reg * weight;
        vq     = prod[63:34];
        re_pos = !re2_reg[23] && (re2_reg != 24'sd0);
        d3_next          = '0;
        d3_next.x        = XY_W'(re2_reg);
        d3_next.y        = signed'(XY_W'(mag2_reg));
        d3_next.z        = '0;
        d3_next.rem      = re2_reg;
        d3_next.mag      = mag2_reg;
        d3_next.quot     = '0;
        d3_next.v        = (vq > 30'(ONE_Q16)) ? ONE_Q16 : vq[16:0];
        d3_next.re_pos   = re_pos;
        d3_next.sat_full = re_pos && (re2_reg[23:0] >= mag2_reg);
        d3_next.active   = lvl2_reg > LEVEL_HALF;
        d3_next.last     = last2_reg;
    end

    assign out_vld  = vld3_reg;
    assign out_data = d3_reg;

endmodule
`default_nettype wire

>>> rtl/fbrgb_cell.sv
// One chain cell: a CORDIC vectoring step and a restoring divide step
`timescale 1ns / 1ps
`default_nettype none
module fbrgb_cell
    import fbrgb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [IDX_W-1:0] idx,
    input  wire logic             in_vld,
    input  wire cell_data_t       in_data,
    output logic                  out_vld,
    output cell_data_t            out_data
);

    logic                   vld_reg;
    cell_data_t             d_reg, d_next;
    logic signed [XY_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  da;
    logic [24:0]            rem2;
    logic                   take;

    always_comb
    begin
        d_next = in_data;
        dx     = in_data.y >>> idx;
        dy     = in_data.x >>> idx;
        da     = signed'(Z_W'(atan_q16(5'(idx))));
        rem2   = {in_data.rem, 1'b0};
        take   = rem2 >= {1'b0, in_data.mag};
        if (32'(idx) < ANGLE_STEPS)
        begin
            if (!in_data.y[XY_W-1])
            begin
                d_next.x = in_data.x + dx;
                d_next.y = in_data.y - dy;
                d_next.z = in_data.z + da;
            end
            else
            begin
                d_next.x = in_data.x - dx;
                d_next.y = in_data.y + dy;
                d_next.z = in_data.z - da;
            end
        end
        if (32'(idx) < DIV_STEPS)
        begin
            d_next.rem  = take ? 24'(rem2 - {1'b0, in_data.mag}) : rem2[23:0];
            d_next.quot = {in_data.quot[14:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = d_reg;

endmodule
`default_nettype wire

>>> rtl/fbrgb_tail.sv
// Back stages: hue sector split, p/q/t products and channel scaling
`timescale 1ns / 1ps
`default_nettype none
module fbrgb_tail
    import fbrgb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_vld,
    input  wire cell_data_t in_data,
    output logic            out_vld,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue,
    output logic            last
);

    function automatic logic [7:0] to_channel(input logic [16:0] x);
        logic [24:0] m;
        m = {x, 8'b0} - 25'(x);
        return m[23:16];
    endfunction

    logic [4:0]  vld_reg;
    // stage 1
    logic [16:0] s1_reg, v1_reg;
    logic [21:0] n1_reg;
    logic        sec1_reg, act1_reg, last1_reg;
    logic [16:0] s_next;
    logic [22:0] hue;
    // stage 2
    logic [16:0] s2_reg, v2_reg;
    logic [44:0] fp2_reg;
    logic        sec2_reg, act2_reg, last2_reg;
    // stage 3
    logic [16:0] s3_reg, v3_reg, sff3_reg, sf13_reg;
    logic        sec3_reg, act3_reg, last3_reg;
    logic [15:0] ff;
    logic [32:0] sff_p;
    logic [33:0] sf1_p;
    // stage 4
    logic [16:0] p4_reg, q4_reg, t4_reg, v4_reg;
    logic        grey4_reg, sec4_reg, act4_reg, last4_reg;
    logic [33:0] p_p, q_p, t_p;
    // stage 5
    logic [7:0]  r5_reg, g5_reg, b5_reg, r5_next, g5_next, b5_next;
    logic        last5_reg;

    always_comb
    begin
        if (!in_data.re_pos)
        begin
            s_next = '0;
        end
        else if (in_data.sat_full)
        begin
            s_next = ONE_Q16;
        end
        else
        begin
            s_next = {1'b0, in_data.quot};
        end
        if (in_data.z[Z_W-1])
        begin
            hue = '0;
        end
        else if (in_data.z > signed'(Z_W'(HUE_MAX)))
        begin
            hue = HUE_MAX;
        end
        else
        begin
            hue = in_data.z[22:0];
        end
    end

    always_comb
    begin
        ff    = fp2_reg[RECIP_SH+15:RECIP_SH];
        sff_p = s2_reg * ff;
        sf1_p = s2_reg * (ONE_Q16 - 17'(ff));
        p_p   = v3_reg * (ONE_Q16 - s3_reg);
        q_p   = v3_reg * (ONE_Q16 - sff3_reg);
        t_p   = v3_reg * (ONE_Q16 - sf13_reg);
    end

    always_comb
    begin
        if (!act4_reg)
        begin
            r5_next = '0;
            g5_next = '0;
            b5_next = '0;
        end
        else if (grey4_reg)
        begin
            r5_next = to_channel(v4_reg);
            g5_next = to_channel(v4_reg);
            b5_next = to_channel(v4_reg);
        end
        else if (sec4_reg)
        begin
            r5_next = to_channel(q4_reg);
            g5_next = to_channel(v4_reg);
            b5_next = to_channel(p4_reg);
        end
        else
        begin
            r5_next = to_channel(v4_reg);
            g5_next = to_channel(t4_reg);
            b5_next = to_channel(p4_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg    <= s_next;
            v1_reg    <= in_data.v;
            sec1_reg  <= hue >= DEG60_Q16;
            n1_reg    <= (hue >= DEG60_Q16) ? 22'(hue - DEG60_Q16) : hue[21:0];
            act1_reg  <= in_data.active;
            last1_reg <= in_data.last;

            s2_reg    <= s1_reg;
            v2_reg    <= v1_reg;
            fp2_reg   <= n1_reg * RECIP60;
            sec2_reg  <= sec1_reg;
            act2_reg  <= act1_reg;
            last2_reg <= last1_reg;

            s3_reg    <= s2_reg;
            v3_reg    <= v2_reg;
            sff3_reg  <= sff_p[32:16];
            sf13_reg  <= sf1_p[32:16];
            sec3_reg  <= sec2_reg;
            act3_reg  <= act2_reg;
            last3_reg <= last2_reg;

            p4_reg    <= p_p[32:16];
            q4_reg    <= q_p[32:16];
            t4_reg    <= t_p[32:16];
            v4_reg    <= v3_reg;
            grey4_reg <= s3_reg == '0;
            sec4_reg  <= sec3_reg;
            act4_reg  <= act3_reg;
            last4_reg <= last3_reg;

            r5_reg    <= r5_next;
            g5_reg    <= g5_next;
            b5_reg    <= b5_next;
            last5_reg <= last4_reg;
        end
    end

    assign out_vld = vld_reg[4];
    assign red     = r5_reg;
    assign green   = g5_reg;
    assign blue    = b5_reg;
    assign last    = last5_reg;

endmodule
`default_nettype wire

>>> rtl/fbrgb_checker.sv
// Port-level checks for the bin-to-color core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fbrgb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] red,
    input wire logic [7:0] green,
    input wire logic [7:0] blue
);

    `CHK_RESET(a_rst_idle, !rst_n |-> !out_valid)
    `CHK_ALWAYS(a_stall_link, in_stall == (out_valid && out_stall))
    `CHK_ALWAYS(a_blue_min, out_valid |-> (blue <= red) && (blue <= green))
    `CHK_ALWAYS(a_hold, out_valid && out_stall |=> out_valid && $stable(red))

endmodule

bind fft_bin_to_rgb_color_core fbrgb_checker u_fbrgb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red       (red),
    .green     (green),
    .blue      (blue)
);
`default_nettype wire

>>> dv/fft_bin_to_rgb_color_checker.sv
// Checker: predicts pixel colors from accepted bins and compares output beats
`timescale 1ns / 1ps
`default_nettype none
module fft_bin_to_rgb_color_checker
    import fbrgb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [15:0]        cfg_wr_data,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic signed [23:0] real_part,
    input  wire logic [23:0]        magnitude,
    input  wire logic [15:0]        level,
    input  wire logic               last_bin,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [7:0]         red,
    input  wire logic [7:0]         green,
    input  wire logic [7:0]         blue,
    input  wire logic               last_pixel,
    output int                      fail_count,
    output int                      pending
);

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       last;
    } pixel_t;

    localparam int HUE_STEPS = 16;
    localparam longint DEG60 = 64'd3932160;
    localparam longint DEG90 = 64'd5898240;

    logic [15:0] weight;
    pixel_t      pixel_q[$];

    // atan(2^-i) in degrees, Q.16
    function automatic longint atan_deg(input int i);
        longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                            57, 29, 14, 7, 4, 2, 1, 0};
        return tbl[i];
    endfunction

    function automatic longint hue_of(input longint x0, input longint y0);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = x0;
        y = y0;
        z = 0;
        for (int i = 0; i < HUE_STEPS; i++)
        begin
            // >>> floors for negative values
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += atan_deg(i);
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= atan_deg(i);
            end
        end
        if (z < 0)
            z = 0;
        if (z > DEG90 - 1)
            z = DEG90 - 1;
        return z;
    endfunction

    function automatic logic [7:0] chan(input longint x);
        return 8'((x * 255) >> 16);
    endfunction

    function automatic pixel_t bin_color(input logic signed [23:0] re_in,
                                         input logic [23:0] mag_in,
                                         input logic [15:0] lvl_in,
                                         input logic lb);
        pixel_t px;
        longint re;
        longint mag;
        longint lv;
        longint v;
        longint s;
        longint hue;
        longint ff;
        longint p;
        longint q;
        longint t;
        logic   sec1;
        px = '0;
        px.last = lb;
        re = re_in;
        mag = mag_in;
        lv = lvl_in;
        if (lvl_in > LEVEL_HALF)
        begin
            // level^3 * weight can exceed 2^63; hold the shift in unsigned math
            v = longint'((64'(lv * lv * lv) * 64'(weight)) >> 34);
            if (v > 65536)
                v = 65536;
            if (re <= 0)
                s = 0;
            else if (re >= mag)
                s = 65536;
            else
                s = (re << 16) / mag;
            if (s == 0)
            begin
                px.r = chan(v);
                px.g = chan(v);
                px.b = chan(v);
            end
            else
            begin
                hue = hue_of(re, mag);
                sec1 = hue >= DEG60;
                ff = (sec1 ? hue - DEG60 : hue) / 60;
                p = (v * (65536 - s)) >> 16;
                q = (v * (65536 - ((s * ff) >> 16))) >> 16;
                t = (v * (65536 - ((s * (65536 - ff)) >> 16))) >> 16;
                px.r = sec1 ? chan(q) : chan(v);
                px.g = sec1 ? chan(v) : chan(t);
                px.b = chan(p);
            end
        end
        return px;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    assign pending = pixel_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            weight <= 16'd256;
            fail_count = 0;
            pixel_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
                weight <= cfg_wr_data;
            if (in_valid && !in_stall)
                pixel_q.push_back(bin_color(real_part, magnitude, level, last_bin));
            if (out_valid && !out_stall)
            begin
                if (pixel_q.size() == 0)
                    report("unexpected beat, red", red, 0);
                else
                begin
                    want = pixel_q.pop_front();
                    if (red != want.r)
                        report("red", red, want.r);
                    if (green != want.g)
                        report("green", green, want.g);
                    if (blue != want.b)
                        report("blue", blue, want.b);
                    if (last_pixel != want.last)
                        report("last_pixel", last_pixel, want.last);
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> dv/tb_fft_bin_to_rgb_color_core.sv
// Testbench top: clock, reset, bin stimulus, weight phases and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_fft_bin_to_rgb_color_core;
    import fbrgb_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [15:0]        cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [23:0] real_part;
    logic [23:0]        magnitude;
    logic [15:0]        level;
    logic               last_bin;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               last_pixel;
    int                 fail_count;
    int                 pending;
    bit                 calm;
    int                 bins_sent;

    fft_bin_to_rgb_color_core DUT (.*);

    fft_bin_to_rgb_color_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver stalls at random except in calm stretches
    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < 11);

    // valid stays high after a beat until the next bin replaces it; an idle cycle or a drain drops it
    task automatic send_bin(input logic signed [23:0] re, input logic [23:0] mag,
                            input logic [15:0] lvl, input logic lb);
        while (!calm && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        real_part <= re;
        magnitude <= mag;
        level     <= lvl;
        last_bin  <= lb;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        bins_sent++;
    endtask

    task automatic set_weight(input logic [15:0] w);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_bin();
        logic signed [23:0] re;
        logic [23:0]        mag;
        logic [15:0]        lvl;
        mag = 24'($urandom());
        case ($urandom_range(5))
            0: re = 24'($urandom());
            1: re = -$signed({1'b0, 23'($urandom())});
            2: re = 24'($urandom_range(1, 255));
            default: re = $signed({1'b0, 23'(mag >> $urandom_range(0, 8))});
        endcase
        if ($urandom_range(3) == 0)
            mag = mag >> $urandom_range(0, 23);
        lvl = ($urandom_range(4) == 0) ? 16'($urandom_range(0, 8192))
                                       : 16'($urandom_range(8193, 65535));
        send_bin(re, mag, lvl, $urandom_range(7) == 0);
    endtask

    initial
    begin
        logic [15:0] weights[4] = '{16'd0, 16'hFFFF, 16'd64, 16'($urandom())};
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        real_part = '0;
        magnitude = '0;
        level = '0;
        last_bin = 1'b0;
        calm = 1'b0;
        bins_sent = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed corners at reset weight
        send_bin(24'sd1000, 24'd2000, 16'd8192, 1'b0);
        send_bin(24'sd1000, 24'd2000, 16'd8193, 1'b0);
        send_bin(24'sd0, 24'd5000, 16'hFFFF, 1'b0);
        send_bin(-24'sd8388608, 24'hFFFFFF, 16'hFFFF, 1'b1);
        send_bin(24'sd500, 24'd0, 16'd40000, 1'b0);
        send_bin(24'sd8388607, 24'd100, 16'd30000, 1'b0);
        send_bin(24'sd1, 24'hFFFFFF, 16'd50000, 1'b0);
        send_bin(24'sd1000, 24'd1001, 16'd20000, 1'b0);
        send_bin(24'sd1000, 24'd3000, 16'd20000, 1'b0);
        send_bin(24'sd8388607, 24'hFFFFFF, 16'hFFFF, 1'b1);
        send_bin(24'sd100, 24'd10000, 16'd16384, 1'b0);
        send_bin(24'sd7000, 24'd10000, 16'd0, 1'b1);

        for (int ph = 0; ph < 4; ph++)
        begin
            set_weight(weights[ph]);
            send_bin(24'sd4000, 24'd8000, 16'hFFFF, 1'b0);
            send_bin(24'sd4000, 24'd5000, 16'd9000, 1'b0);
            for (int i = 0; i < 110; i++)
            begin
                calm = (i >= 40 && i < 70);
                random_bin();
            end
            calm = 1'b0;
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        $display("Sent %0d bins over five brightness weights incl. 0 and 0xFFFF,", bins_sent);
        $display("with black, grey, clamped and both hue sectors under random stalls.");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
